/* hw/rtl/ptwm_pkg.sv */
// Shared constants, codes and helpers for the page table walker and mapper.
`timescale 1ns / 1ps

package ptwm_pkg;

  // Table store geometry
  localparam int TABLE_PAGES = 64;
  localparam int WALK_LEVELS = 2;
  localparam int SLOT_W      = 9;
  localparam int SLOTS       = 1 << SLOT_W;
  localparam int PIDX_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int ADDR_W      = PIDX_W + SLOT_W;
  localparam int DEPTH       = TABLE_PAGES * SLOTS;
  localparam int PCNT_W      = $clog2(TABLE_PAGES + 1);
  localparam int LVL_W       = $clog2(WALK_LEVELS + 1);

  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(WALK_LEVELS);

  // Field widths
  localparam int VA_W      = 39;
  localparam int PA_W      = 56;
  localparam int PTE_W     = 64;
  localparam int PPN_W     = 44;
  localparam int VA_END_W  = 40;
  localparam int OUT_LVL_W = 2;
  localparam int OUT_LOC_W = 15;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 88;

  // Entry bits
  localparam logic [PTE_W-1:0] PTE_V   = 64'h1;
  localparam logic [PTE_W-1:0] PTE_RWX = 64'hE;
  localparam logic [PTE_W-1:0] PTE_AD  = 64'hC0;

  // Operations
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_MAP    = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 44;
  localparam logic [CFG_IDX_W-1:0] CFG_VA_END     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE = 1'b1;

  localparam logic [VA_END_W-1:0] VA_END_RST     = 40'h40_0000_0000;
  localparam logic [PPN_W-1:0]    TABLE_BASE_RST = 44'h80000;

  typedef enum logic [2:0] {
    STS_OK           = 3'd0,
    STS_NOT_PRESENT  = 3'd1,
    STS_OUT_OF_PAGES = 3'd2,
    STS_REMAP        = 3'd3,
    STS_OUT_OF_RANGE = 3'd4,
    STS_BAD_POINTER  = 3'd5,
    STS_SKIPPED      = 3'd6
  } status_e;

  typedef struct packed {
    status_e                status;
    logic [OUT_LVL_W-1:0]   level;
    logic [PTE_W-1:0]       value;
    logic [OUT_LOC_W-1:0]   loc;
  } result_t;

  // 9-bit VPN slice of an address at a given level
  function automatic logic [SLOT_W-1:0] vpn_slice(logic [VA_W-1:0] va, logic [LVL_W-1:0] lvl);
    logic [63:0]       wide;
    logic [SLOT_W-1:0] s;
    wide = 64'(va);
    s    = '0;
    for (int l = 0; l <= WALK_LEVELS; l++) begin
      if (LVL_W'(l) == lvl) begin
        s = wide[12 + SLOT_W * l +: SLOT_W];
      end
    end
    return s;
  endfunction

endpackage

/* hw/rtl/page_table_walk_and_map.sv */
// Top level: Sv39-style page table walker and single-page mapper over an internal table store.
`timescale 1ns / 1ps

// Usage: each item on the slave stream is a lookup (tuser[0] = 0) or a one-page map
// (tuser[0] = 1); tuser[1] marks the first page of a map range. Every item yields exactly
// one result item on the master stream: status, end level, final entry and its location.
// Two registers (address limit, table base PPN) are written through the cfg port; the user
// must write them only while idle, as the block itself does not enforce it.
// Timing: the walk reads one entry per cycle from the table store RAM, one per level from the
// root down; a walk that stops early reads fewer, and a skipped or out-of-range item
// is settled in its accept cycle with no walk. Results leave through the output register.
// Reset: the store is swept to zero one entry a cycle, over all DEPTH entries (32768 with 64
// pages), during which s_axis_tready stays low; config writes are taken throughout.
// Stall: a result waits in the output register; the next item is already accepted and walked,
// and its result is held internally until the output register frees up, while tready is low.
module page_table_walk_and_map
  import ptwm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // slave stream; tdata: va, pa, permission, zero pad
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: op, range_first
  input  logic [1:0]              s_axis_tuser,
  // master stream; tdata: status, stop level, entry_value, entry_location, zero pad
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_DATA_W-1:0]   m_axis_tdata,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_RESP
  } state_e;

  state_e               state_q, state_d;
  logic [ADDR_W-1:0]    clr_q, clr_d;
  logic [PCNT_W-1:0]    pages_used_q, pages_used_d;
  logic                 range_failed_q, range_failed_d;
  logic [VA_END_W-1:0]  va_end_q, va_end_d;
  logic [PPN_W-1:0]     tbase_q, tbase_d;
  logic                 is_map_q, is_map_d;
  logic [VA_W-1:0]      va_q, va_d;
  logic [PA_W-1:0]      pa_q, pa_d;
  logic [PTE_W-1:0]     perm_q, perm_d;
  logic [LVL_W-1:0]     level_q, level_d;
  logic [PIDX_W-1:0]    page_q, page_d;
  result_t              res_q, res_d;
  logic                 m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  // RAM ports
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [PTE_W-1:0]     wr_data;
  logic [ADDR_W-1:0]    rd_addr;
  logic [PTE_W-1:0]     rd_data;

  // input fields
  logic                 in_op;
  logic                 in_first;
  logic [VA_W-1:0]      in_va;
  logic [PA_W-1:0]      in_pa;
  logic [PTE_W-1:0]     in_perm;

  // walk helpers
  logic                 fin;
  result_t              res;
  logic [ADDR_W-1:0]    loc_cur;
  logic [LVL_W-1:0]     level_dn;
  logic [PPN_W-1:0]     idx;
  logic [PPN_W-1:0]     ppn_new;
  logic [PTE_W-1:0]     pte_table;
  logic [PTE_W-1:0]     pte_leaf;
  logic                 out_free;

  assign in_op    = s_axis_tuser[0];
  assign in_first = s_axis_tuser[1];
  assign in_va    = s_axis_tdata[38:0];
  assign in_pa    = s_axis_tdata[94:39];
  assign in_perm  = s_axis_tdata[158:95];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign out_free  = !m_valid_q || m_axis_tready;
  assign loc_cur   = {page_q, vpn_slice(va_q, level_q)};
  assign level_dn  = level_q - LVL_W'(1);
  assign idx       = rd_data[10 +: PPN_W] - tbase_q;
  assign ppn_new   = tbase_q + PPN_W'(pages_used_q);
  assign pte_table = {10'b0, ppn_new, 10'b0} | PTE_V;
  assign pte_leaf  = {10'b0, pa_q[PA_W-1:12], 10'b0} | PTE_V | PTE_AD | perm_q;

  ptwm_ram #(
    .WIDTH (PTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d        = state_q;
    clr_d          = clr_q;
    pages_used_d   = pages_used_q;
    range_failed_d = range_failed_q;
    va_end_d       = va_end_q;
    tbase_d        = tbase_q;
    is_map_d       = is_map_q;
    va_d           = va_q;
    pa_d           = pa_q;
    perm_d         = perm_q;
    level_d        = level_q;
    page_d         = page_q;
    res_d          = res_q;
    m_valid_d      = m_valid_q;
    m_data_d       = m_data_q;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_addr        = '0;
    fin            = 1'b0;
    res            = '{status: STS_OK, level: '0, value: '0, loc: '0};

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_VA_END:     va_end_d = cfg_wdata_i[VA_END_W-1:0];
        CFG_TABLE_BASE: tbase_d  = cfg_wdata_i[PPN_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        // start the root read speculatively; a skipped or out-of-range item just ignores it
        rd_addr = {PIDX_W'(0), vpn_slice(in_va, LVL_TOP)};
        if (s_axis_tvalid) begin
          is_map_d = in_op;
          va_d     = in_va;
          pa_d     = in_pa;
          perm_d   = in_perm;
          level_d  = LVL_TOP;
          page_d   = '0;
          if (in_op == OP_MAP && in_first) begin
            range_failed_d = 1'b0;
          end
          if (in_op == OP_MAP && !in_first && range_failed_q) begin
            fin        = 1'b1;
            res.status = STS_SKIPPED;
          end else if ({1'b0, in_va} >= va_end_q) begin
            fin        = 1'b1;
            res.status = STS_OUT_OF_RANGE;
          end else begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        res.level = OUT_LVL_W'(level_q);
        res.value = rd_data;
        res.loc   = OUT_LOC_W'(loc_cur);
        if (level_q != '0) begin
          if ((rd_data & PTE_V) == '0) begin
            if (is_map_q == OP_LOOKUP) begin
              fin        = 1'b1;
              res.status = STS_NOT_PRESENT;
            end else if (pages_used_q == PCNT_W'(TABLE_PAGES)) begin
              fin            = 1'b1;
              res.status     = STS_OUT_OF_PAGES;
              range_failed_d = 1'b1;
            end else begin
              // link a fresh table; the sweep after reset left it zeroed
              wr_en        = 1'b1;
              wr_addr      = loc_cur;
              wr_data      = pte_table;
              pages_used_d = pages_used_q + PCNT_W'(1);
              page_d       = pages_used_q[PIDX_W-1:0];
              level_d      = level_dn;
              rd_addr      = {pages_used_q[PIDX_W-1:0], vpn_slice(va_q, level_dn)};
            end
          end else if ((rd_data & PTE_RWX) != '0) begin
            fin        = 1'b1;
            res.status = (is_map_q == OP_MAP) ? STS_REMAP : STS_OK;
          end else if (idx >= PPN_W'(pages_used_q)) begin
            fin        = 1'b1;
            res.status = STS_BAD_POINTER;
          end else begin
            page_d  = idx[PIDX_W-1:0];
            level_d = level_dn;
            rd_addr = {idx[PIDX_W-1:0], vpn_slice(va_q, level_dn)};
          end
        end else begin
          fin = 1'b1;
          if (is_map_q == OP_LOOKUP) begin
            res.status = STS_OK;
          end else if ((rd_data & PTE_V) != '0) begin
            res.status = STS_REMAP;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = loc_cur;
            wr_data    = pte_leaf;
            res.status = STS_OK;
            res.value  = pte_leaf;
          end
        end
      end
      S_RESP: ;
      default: state_d = S_IDLE;
    endcase

    // output register: drop a taken item, then load a new one if there is room
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (state_q == S_RESP) begin
      if (out_free) begin
        m_valid_d = 1'b1;
        m_data_d  = {4'b0, res_q.loc, res_q.value, res_q.level, res_q.status};
        state_d   = S_IDLE;
      end
    end else if (fin) begin
      if (out_free) begin
        m_valid_d = 1'b1;
        m_data_d  = {4'b0, res.loc, res.value, res.level, res.status};
        state_d   = S_IDLE;
      end else begin
        res_d   = res;
        state_d = S_RESP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_q          <= '0;
      pages_used_q   <= PCNT_W'(1);
      range_failed_q <= 1'b0;
      va_end_q       <= VA_END_RST;
      tbase_q        <= TABLE_BASE_RST;
      is_map_q       <= 1'b0;
      va_q           <= '0;
      pa_q           <= '0;
      perm_q         <= '0;
      level_q        <= '0;
      page_q         <= '0;
      res_q          <= '{status: STS_OK, level: '0, value: '0, loc: '0};
      m_valid_q      <= 1'b0;
      m_data_q       <= '0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      pages_used_q   <= pages_used_d;
      range_failed_q <= range_failed_d;
      va_end_q       <= va_end_d;
      tbase_q        <= tbase_d;
      is_map_q       <= is_map_d;
      va_q           <= va_d;
      pa_q           <= pa_d;
      perm_q         <= perm_d;
      level_q        <= level_d;
      page_q         <= page_d;
      res_q          <= res_d;
      m_valid_q      <= m_valid_d;
      m_data_q       <= m_data_d;
    end
  end

`ifndef SYNTHESIS
  a_pages_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pages_used_q >= PCNT_W'(1) && pages_used_q <= PCNT_W'(TABLE_PAGES))
    else $error("pages_used out of bounds");

  a_pages_only_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_EVAL |=> $stable(pages_used_q))
    else $error("pages_used changed outside a walk");

  a_walk_write_in_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && state_q == S_EVAL |-> PCNT_W'(wr_addr[ADDR_W-1:SLOT_W]) < pages_used_q)
    else $error("table write beyond allocated pages");

  a_no_accept_while_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !s_axis_tready && !m_valid_q)
    else $error("stream activity during the clearing sweep");
`endif

endmodule

/* hw/rtl/ptwm_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module ptwm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
